// File: hw/rtl/ptt_pkg.sv
// Shared codes, widths and field layouts of the periodic task timer bank.
package ptt_pkg;

    localparam int OP_W     = 2;
    localparam int PERIOD_W = 31;
    localparam int HANDLE_W = 7;
    localparam int KIND_W   = 3;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // Operation codes carried on s_tuser.
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_SET    = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Result kinds carried on m_tuser.
    localparam logic [KIND_W-1:0] KIND_ADDED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET_DONE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUE      = 3'd4;

    // Bit positions of the input fields inside s_tdata.
    localparam int IN_INTERVAL_LSB = 0;
    localparam int IN_HANDLE_LSB   = IN_INTERVAL_LSB + PERIOD_W;
    localparam int IN_ACTIVE_LSB   = IN_HANDLE_LSB + HANDLE_W;

endpackage

// File: hw/rtl/ptt_slot_mem.sv
// Synchronous slot memory holding each slot's period and deadline.
module ptt_slot_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 63
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data is registered and holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/periodic_task_timer_bank.sv
// Top level of the periodic task timer bank: control sequencer, slot state and output register.
//
// The block holds SLOT_COUNT periodic timer slots. Each transaction on the slave side is one
// command: a tick advances the time counter by one and then reports every active slot whose
// deadline has been reached, in ascending handle order, with tlast on the final report; an add
// takes the next free slot (inactive, with the given interval) and answers with its handle or a
// full indication; a set changes one slot's enable, and only a change from inactive to active
// reloads its deadline to now plus interval. Deadlines are compared wrap-safe: a slot is due when
// the signed difference now minus deadline is not negative. Periods and deadlines live in a
// single-port-read, single-port-write memory with a registered read port; the enables sit in
// flip-flops. Commands are handled one at a time. After its transaction an add keeps the slave
// side closed until the output register is free; a set does the same after it has checked the
// handle and, for a known handle, read the slot. A tick keeps the side closed while the scan
// reads one slot from the memory per cycle unless stalled, overlapping the read of the next
// slot with the compare and write-back of the current one, then evaluates the last slot, sees
// that the scan is done and hands over the final report, if any. A consumer that stalls the
// master side stretches the scan. A result waiting in the output register does not block
// acceptance of the next command. After reset the block is ready at once; no memory clearing
// pass is needed because a slot is always written by its add before any read.
module periodic_task_timer_bank #(
    parameter int SLOT_COUNT = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Slave side.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: interval [30:0], handle [37:31], active_value [38], zero fill [39].
    input  logic [ptt_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: operation [1:0].
    input  logic [ptt_pkg::OP_W-1:0]       s_tuser,
    // Master side.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: handle_res [6:0], zero fill [7].
    output logic [ptt_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: kind [2:0].
    output logic [ptt_pkg::KIND_W-1:0]     m_tuser,
    output logic                           m_tlast
);

    import ptt_pkg::*;

    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SUM_W   = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;
    localparam int ENTRY_W = PERIOD_W + TIME_BITS;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_ADD     = 6'b000010,
        ST_SET_CHK = 6'b000100,
        ST_SET_UPD = 6'b001000,
        ST_SCAN    = 6'b010000,
        ST_FLUSH   = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [TIME_BITS-1:0]   time_reg, time_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [SLOT_COUNT-1:0]  enable_reg, enable_next;

    // Latched command payload.
    logic [PERIOD_W-1:0]    interval_reg, interval_next;
    logic [HANDLE_W-1:0]    hdl_reg, hdl_next;
    logic                   act_reg, act_next;

    // Scan pipeline: one slot read while the previous one is evaluated.
    logic [CNT_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   eval_valid_reg, eval_valid_next;
    logic [SLOT_IW-1:0]     eval_idx_reg, eval_idx_next;

    // The most recent due slot is held back until it is known whether it is the last one.
    logic                   pend_valid_reg, pend_valid_next;
    logic [HANDLE_W-1:0]    pend_handle_reg, pend_handle_next;

    logic                   out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]      out_kind_reg, out_kind_next;
    logic [HANDLE_W-1:0]    out_handle_reg, out_handle_next;
    logic                   out_last_reg, out_last_next;

    logic                   mem_wr_en;
    logic [SLOT_IW-1:0]     mem_wr_addr;
    logic [ENTRY_W-1:0]     mem_wr_data;
    logic                   mem_rd_en;
    logic [SLOT_IW-1:0]     mem_rd_addr;
    logic [ENTRY_W-1:0]     mem_rd_data;

    logic [PERIOD_W-1:0]    rd_period;
    logic [TIME_BITS-1:0]   rd_deadline;
    logic [SUM_W-1:0]       reload_sum;
    logic [TIME_BITS-1:0]   reload_deadline;
    logic [TIME_BITS-1:0]   due_diff;
    logic                   slot_due;

    logic                   out_free;
    logic                   push;
    logic [KIND_W-1:0]      push_kind;
    logic [HANDLE_W-1:0]    push_handle;
    logic                   push_last;

    logic                   in_accept;
    logic                   scan_issue;
    logic                   scan_hit;
    logic                   scan_stall;
    logic                   set_handle_ok;
    logic [SLOT_IW-1:0]     set_slot;

    ptt_slot_mem #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (SLOT_IW),
        .DATA_W (ENTRY_W)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Memory entry layout: deadline in the low bits, period above it.
    assign rd_deadline     = mem_rd_data[TIME_BITS-1:0];
    assign rd_period       = mem_rd_data[ENTRY_W-1:TIME_BITS];
    assign reload_sum      = SUM_W'(time_reg) + SUM_W'(rd_period);
    assign reload_deadline = reload_sum[TIME_BITS-1:0];
    assign due_diff        = time_reg - rd_deadline;
    assign slot_due        = ~due_diff[TIME_BITS-1];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid & s_tready;
    assign out_free  = ~out_valid_reg | m_tready;

    assign scan_issue    = (scan_idx_reg != used_reg);
    assign scan_hit      = eval_valid_reg & enable_reg[eval_idx_reg] & slot_due;
    assign scan_stall    = scan_hit & pend_valid_reg & ~out_free;
    assign set_handle_ok = (hdl_reg != '0) && (hdl_reg <= HANDLE_W'(used_reg));
    assign set_slot      = SLOT_IW'(hdl_reg - HANDLE_W'(1));

    always_comb
    begin
        state_next       = state_reg;
        time_next        = time_reg;
        used_next        = used_reg;
        enable_next      = enable_reg;
        interval_next    = interval_reg;
        hdl_next         = hdl_reg;
        act_next         = act_reg;
        scan_idx_next    = scan_idx_reg;
        eval_valid_next  = eval_valid_reg;
        eval_idx_next    = eval_idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = eval_idx_reg;
        mem_wr_data = {rd_period, reload_deadline};
        mem_rd_en   = 1'b0;
        mem_rd_addr = scan_idx_reg[SLOT_IW-1:0];

        push        = 1'b0;
        push_kind   = KIND_DUE;
        push_handle = pend_handle_reg;
        push_last   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    interval_next = s_tdata[IN_INTERVAL_LSB +: PERIOD_W];
                    hdl_next      = s_tdata[IN_HANDLE_LSB +: HANDLE_W];
                    act_next      = s_tdata[IN_ACTIVE_LSB];
                    unique case (s_tuser)
                        OP_TICK:
                        begin
                            time_next       = time_reg + TIME_BITS'(1);
                            scan_idx_next   = '0;
                            eval_valid_next = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        OP_ADD:
                        begin
                            state_next = ST_ADD;
                        end
                        OP_SET:
                        begin
                            state_next = ST_SET_CHK;
                        end
                        OP_UNUSED:
                        begin
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ADD:
            begin
                if (out_free)
                begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    if (used_reg == CNT_W'(SLOT_COUNT))
                    begin
                        push_kind   = KIND_FULL;
                        push_handle = '0;
                    end
                    else
                    begin
                        // New slot starts inactive with a zero deadline.
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = used_reg[SLOT_IW-1:0];
                        mem_wr_data = {interval_reg, {TIME_BITS{1'b0}}};
                        enable_next[used_reg[SLOT_IW-1:0]] = 1'b0;
                        used_next   = used_reg + CNT_W'(1);
                        push_kind   = KIND_ADDED;
                        push_handle = HANDLE_W'(used_reg) + HANDLE_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SET_CHK:
            begin
                if (set_handle_ok)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = set_slot;
                    state_next  = ST_SET_UPD;
                end
                else if (out_free)
                begin
                    push        = 1'b1;
                    push_kind   = KIND_UNKNOWN;
                    push_handle = hdl_reg;
                    push_last   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_SET_UPD:
            begin
                if (out_free)
                begin
                    // Only an inactive-to-active change reloads the deadline.
                    if (!enable_reg[set_slot] && act_reg)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = set_slot;
                    end
                    enable_next[set_slot] = act_reg;
                    push        = 1'b1;
                    push_kind   = KIND_SET_DONE;
                    push_handle = hdl_reg;
                    push_last   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (!scan_stall)
                begin
                    mem_rd_en       = scan_issue;
                    scan_idx_next   = scan_idx_reg + CNT_W'(scan_issue);
                    eval_valid_next = scan_issue;
                    eval_idx_next   = scan_idx_reg[SLOT_IW-1:0];
                    if (scan_hit)
                    begin
                        mem_wr_en = 1'b1;
                        // A later due slot exists, so the held one is not the last.
                        push             = pend_valid_reg;
                        pend_valid_next  = 1'b1;
                        pend_handle_next = HANDLE_W'(eval_idx_reg) + HANDLE_W'(1);
                    end
                    if (!scan_issue && !eval_valid_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next  = push | (out_valid_reg & ~m_tready);
    assign out_kind_next   = push ? push_kind   : out_kind_reg;
    assign out_handle_next = push ? push_handle : out_handle_reg;
    assign out_last_next   = push ? push_last   : out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            time_reg        <= '0;
            used_reg        <= '0;
            enable_reg      <= '0;
            scan_idx_reg    <= '0;
            eval_valid_reg  <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            time_reg        <= time_next;
            used_reg        <= used_next;
            enable_reg      <= enable_next;
            scan_idx_reg    <= scan_idx_next;
            eval_valid_reg  <= eval_valid_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        interval_reg    <= interval_next;
        hdl_reg         <= hdl_next;
        act_reg         <= act_next;
        eval_idx_reg    <= eval_idx_next;
        pend_handle_reg <= pend_handle_next;
        out_kind_reg    <= out_kind_next;
        out_handle_reg  <= out_handle_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_handle_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hw/rtl/ptt_checker.sv
// Port-level checker for the periodic task timer bank and its bind statement.
module ptt_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ptt_pkg::OP_W-1:0]       s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ptt_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [ptt_pkg::KIND_W-1:0]     m_tuser,
    input  logic                           m_tlast
);

    import ptt_pkg::*;

    // A stalled result transaction keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
    else $error("stalled result changed");

    // Only due reports may come without the last mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_DUE |-> m_tlast)
    else $error("single result without last mark");

    // A refused add carries handle zero; every other result carries a real handle
    // except an unknown-handle report.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_FULL |-> m_tdata == '0)
    else $error("refused add with nonzero handle");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ADDED || m_tuser == KIND_DUE) |-> m_tdata != '0)
    else $error("added or due result with handle zero");

    // Any real command keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser != OP_UNUSED |=> !s_tready)
    else $error("command accepted without a busy cycle");

endmodule

bind periodic_task_timer_bank ptt_checker u_ptt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: test/ptt_checker.sv
// Scoreboard for the periodic task timer bank: predicts the reports of each command and checks them.
`timescale 1ns / 100ps
module ptt_scoreboard #(
    parameter int SLOT_COUNT = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ptt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [ptt_pkg::OP_W-1:0]       s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ptt_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [ptt_pkg::KIND_W-1:0]     m_tuser,
    input  logic                           m_tlast,
    output int                             failures,
    output int                             pending
);

    import ptt_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } timer_report_t;

    // Shadow copy of the timer bank.
    logic [TIME_BITS-1:0] now_ticks;
    int unsigned          slots_taken;
    logic                 slot_on       [SLOT_COUNT];
    logic [PERIOD_W-1:0]  slot_interval [SLOT_COUNT];
    logic [TIME_BITS-1:0] slot_due_at   [SLOT_COUNT];

    timer_report_t pending_reports[$];

    task automatic queue_report(input logic [KIND_W-1:0] kind,
                                input logic [HANDLE_W-1:0] handle, input logic last);
        timer_report_t rep;
        rep.kind   = kind;
        rep.handle = handle;
        rep.last   = last;
        pending_reports = {pending_reports, rep};
    endtask

    task automatic predict_command(input logic [OP_W-1:0] op,
                                   input logic [PERIOD_W-1:0] interval,
                                   input logic [HANDLE_W-1:0] handle,
                                   input logic active);
        int fired;
        int idx;
        logic [TIME_BITS-1:0] lag;
        timer_report_t final_rep;
        fired = 0;
        case (op)
            OP_ADD:
            begin
                if (slots_taken >= SLOT_COUNT)
                begin
                    queue_report(KIND_FULL, '0, 1'b1);
                end
                else
                begin
                    slot_on[slots_taken]       = 1'b0;
                    slot_interval[slots_taken] = interval;
                    slot_due_at[slots_taken]   = '0;
                    slots_taken++;
                    queue_report(KIND_ADDED, HANDLE_W'(slots_taken), 1'b1);
                end
            end
            OP_SET:
            begin
                if (handle == 0 || handle > slots_taken)
                begin
                    queue_report(KIND_UNKNOWN, handle, 1'b1);
                end
                else
                begin
                    idx = int'(handle) - 1;
                    // Only an inactive-to-active change reloads the deadline.
                    if (!slot_on[idx] && active)
                        slot_due_at[idx] = now_ticks + TIME_BITS'(slot_interval[idx]);
                    slot_on[idx] = active;
                    queue_report(KIND_SET_DONE, handle, 1'b1);
                end
            end
            OP_TICK:
            begin
                now_ticks = now_ticks + 1'b1;
                for (idx = 0; idx < int'(slots_taken); idx++)
                begin
                    // Due when the wrapped difference is not negative.
                    lag = now_ticks - slot_due_at[idx];
                    if (slot_on[idx] && !lag[TIME_BITS-1])
                    begin
                        slot_due_at[idx] = now_ticks + TIME_BITS'(slot_interval[idx]);
                        queue_report(KIND_DUE, HANDLE_W'(idx + 1), 1'b0);
                        fired++;
                    end
                end
                if (fired > 0)
                begin
                    final_rep      = pending_reports[pending_reports.size() - 1];
                    final_rep.last = 1'b1;
                    pending_reports[pending_reports.size() - 1] = final_rep;
                end
            end
            default:
            begin
                // The unused operation code is dropped without a report.
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        timer_report_t seen;
        timer_report_t want;
        if (!rst_n)
        begin
            now_ticks   = '0;
            slots_taken = 0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_on[i]       = 1'b0;
                slot_interval[i] = '0;
                slot_due_at[i]   = '0;
            end
            pending_reports.delete();
            failures = 0;
            pending  = 0;
        end
        else
        begin
            // A report leaving now belongs to an earlier command, so check before predicting.
            if (m_tvalid && m_tready)
            begin
                seen.kind   = m_tuser;
                seen.handle = m_tdata[HANDLE_W-1:0];
                seen.last   = m_tlast;
                if (pending_reports.size() == 0)
                begin
                    $display("%0t: expected no report, got kind %0d handle %0d last %0d",
                             $time, seen.kind, seen.handle, seen.last);
                    failures++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (seen.kind !== want.kind || seen.handle !== want.handle
                        || seen.last !== want.last)
                    begin
                        $display("%0t: kind/handle/last expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $time, want.kind, want.handle, want.last,
                                 seen.kind, seen.handle, seen.last);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_command(s_tuser, s_tdata[IN_INTERVAL_LSB +: PERIOD_W],
                                s_tdata[IN_HANDLE_LSB +: HANDLE_W], s_tdata[IN_ACTIVE_LSB]);
            pending = pending_reports.size();
        end
    end

endmodule

// File: test/tb.sv
// Testbench top for the periodic task timer bank: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps
module tb;
    import ptt_pkg::*;

    // Number of random commands that count toward the run (ignored opcodes do not count).
    localparam int RANDOM_COMMANDS = 130;
    // The bank instantiated below keeps its default slot count.
    localparam int BANK_SLOTS      = 16;
    // A tick scan lasts longer with more slots in use and is stretched by a stalling consumer,
    // so this many quiet cycles at the end lets any stray report show up.
    localparam int DRAIN_CYCLES    = 60;
    // Length of the one long consumer stall that fills the block and blocks its input.
    localparam int HOLD_OFF_CYCLES = 250;
    // Far above the slowest correct run: every tick firing all slots under random stalls.
    localparam int CYCLE_LIMIT     = 100000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;

    int failures;
    int pending;
    int cycle_count = 0;

    // Stimulus-side bookkeeping only: how many slots have been handed out, so that most
    // set commands address a live handle.
    int slots_added = 0;

    // calm turns off idling on both sides; hold_req asks the consumer for its long stall.
    bit calm      = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_used = 1'b0;

    periodic_task_timer_bank uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ptt_scoreboard checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Watchdog: a hung block or a lost report ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL periodic_task_timer_bank");
            $finish;
        end
    end

    // Consumer side. It is ready with a chance of about two in three, never idles while calm
    // is set, and once on request holds tready low for a long stretch so that the output
    // register stays full and the block must stall its input.
    always @(negedge clk)
    begin
        if (hold_req && !hold_used)
        begin
            hold_used = 1'b1;
            m_tready  = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clk);
        end
        m_tready = calm || ($urandom_range(0, 99) >= 34);
    end

    // Presents one command and waits for its transaction. Random gaps come first, so the
    // valid line only drops when a gap is really wanted and stays high between
    // back-to-back commands.
    task automatic offer_command(input logic [OP_W-1:0] op,
                                 input logic [PERIOD_W-1:0] interval,
                                 input logic [HANDLE_W-1:0] handle,
                                 input logic active);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[IN_INTERVAL_LSB +: PERIOD_W] = interval;
        word[IN_HANDLE_LSB +: HANDLE_W]   = handle;
        word[IN_ACTIVE_LSB]               = active;
        while (!calm && $urandom_range(0, 99) < 34)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = word;
        do
            @(posedge clk);
        while (!s_tready);
        if (op == OP_ADD && slots_added < BANK_SLOTS)
            slots_added++;
    endtask

    // A tick ignores its data fields, so they carry random bits.
    task automatic offer_tick();
        offer_command(OP_TICK, PERIOD_W'($urandom), HANDLE_W'($urandom), 1'($urandom));
    endtask

    // Mostly short periods so slots fire often, sometimes wide or the largest period.
    function automatic logic [PERIOD_W-1:0] pick_interval();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return PERIOD_W'($urandom_range(0, 5));
        else if (roll < 85)
            return PERIOD_W'($urandom_range(6, 40));
        else if (roll < 95)
            return PERIOD_W'($urandom);
        else
            return {PERIOD_W{1'b1}};
    endfunction

    initial
    begin
        int issued;
        int roll;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_TICK;
        m_tready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. An empty bank: a tick with nothing due, the unused opcode, and
        // set commands on handle zero, handle 64 and a handle not yet handed out.
        offer_tick();
        offer_command(OP_UNUSED, {PERIOD_W{1'b1}}, {HANDLE_W{1'b1}}, 1'b1);
        offer_command(OP_SET, '0, '0, 1'b1);
        offer_command(OP_SET, '0, HANDLE_W'(64), 1'b1);
        offer_command(OP_SET, '0, HANDLE_W'(1), 1'b0);
        // Three slots: zero period (due every tick), the largest period, and a short one.
        offer_command(OP_ADD, '0, '0, 1'b0);
        offer_command(OP_ADD, {PERIOD_W{1'b1}}, '0, 1'b0);
        offer_command(OP_ADD, PERIOD_W'(2), '0, 1'b0);
        offer_command(OP_SET, '0, HANDLE_W'(1), 1'b1);
        offer_command(OP_SET, '0, HANDLE_W'(2), 1'b1);
        offer_command(OP_SET, '0, HANDLE_W'(3), 1'b1);
        // Setting an active slot active again must keep its deadline.
        offer_command(OP_SET, '0, HANDLE_W'(3), 1'b1);
        offer_tick();
        offer_tick();
        offer_tick();
        // Deactivate, let time pass, then reactivate so the deadline reloads.
        offer_command(OP_SET, '0, HANDLE_W'(3), 1'b0);
        offer_command(OP_SET, '0, HANDLE_W'(1), 1'b0);
        offer_tick();
        offer_tick();
        offer_command(OP_SET, '0, HANDLE_W'(3), 1'b1);
        offer_command(OP_SET, '0, HANDLE_W'(4), 1'b1);
        offer_tick();
        offer_tick();

        // Random part: mostly adds, enables on live handles and ticks, so the bank fills,
        // many slots run, and adds on a full bank get refused. A few commands address
        // arbitrary handles and a few carry the unused opcode.
        issued = 0;
        while (issued < RANDOM_COMMANDS)
        begin
            if (issued == 40)
                hold_req = 1'b1;
            calm = (issued >= 80 && issued < 110);
            // Once mid-run the producer withdraws valid and waits until every report is back.
            if (issued == 120)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            roll = $urandom_range(0, 99);
            if (roll < 42)
            begin
                offer_tick();
                issued++;
            end
            else if (roll < 58)
            begin
                offer_command(OP_ADD, pick_interval(), HANDLE_W'($urandom), 1'($urandom));
                issued++;
            end
            else if (roll < 88)
            begin
                offer_command(OP_SET, PERIOD_W'($urandom),
                              HANDLE_W'($urandom_range(1, (slots_added > 0) ? slots_added : 1)),
                              $urandom_range(0, 99) < 65);
                issued++;
            end
            else if (roll < 96)
            begin
                offer_command(OP_SET, PERIOD_W'($urandom), HANDLE_W'($urandom_range(0, 64)),
                              1'($urandom));
                issued++;
            end
            else
            begin
                offer_command(OP_UNUSED, PERIOD_W'($urandom), HANDLE_W'($urandom),
                              1'($urandom));
            end
        end
        calm = 1'b0;

        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (failures == 0 && pending == 0)
            $display("PASS periodic_task_timer_bank");
        else
            $display("FAIL periodic_task_timer_bank");
        $finish;
    end

endmodule
